[hdl/u8u16_pkg.sv]
// Shared types, constants and byte classification for the UTF-8 to UTF-16 transcoder.
package u8u16_pkg;

  localparam int unsigned BUF_DEPTH = 6;
  localparam int unsigned CNT_W     = 3;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [2:0]       flen_t;
  typedef logic [0:0]       cfg_idx_t;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_PAIR_ENABLE = 1'b0;
  localparam cfg_idx_t CFG_REPLACEMENT = 1'b1;

  // Configuration reset values.
  localparam logic        PAIR_ENABLE_RST = 1'b1;
  localparam logic [15:0] REPL_UNIT_RST   = 16'h003F;

  // Code point limits and surrogate bases.
  localparam logic [10:0] MIN_TWO_BYTE   = 11'h080;
  localparam logic [15:0] MIN_THREE_BYTE = 16'h0800;
  localparam logic [15:0] HI_SURR_FIRST  = 16'hD800;
  localparam logic [15:0] HI_SURR_LAST   = 16'hDBFF;
  localparam logic [15:0] LO_SURR_FIRST  = 16'hDC00;
  localparam logic [20:0] SUPP_BASE      = 21'h010000;
  localparam logic [20:0] CODE_MAX       = 21'h10FFFF;

  // One byte with its classification tags.
  typedef struct packed {
    logic [7:0] data;
    flen_t      flen;  // form length when used as a lead, 0 for raw bytes
    logic       cont;  // byte is 10xxxxxx
  } tbyte_t;

  // One queue entry between the front and back parts.
  typedef struct packed {
    tbyte_t tb;
    logic   eos;
  } qitem_t;

  typedef struct packed {
    logic        pair_enable;
    logic [15:0] replacement_unit;
  } cfg_t;

  function automatic flen_t form_length(input logic [7:0] b);
    flen_t len;
    unique casez (b)
      8'b0???????: len = 3'd1;
      8'b110?????: len = 3'd2;
      8'b1110????: len = 3'd3;
      8'b11110???: len = 3'd4;
      8'b111110??: len = 3'd5;
      8'b1111110?: len = 3'd6;
      default:     len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return b[7:6] == 2'b10;
  endfunction

endpackage

[hdl/utf8_to_utf16_transcoder.sv]
// Top level of the UTF-8 to UTF-16 transcoder: configuration registers, front and back parts.
// A byte passes the front queue; the first unit it causes is held in the back output register.
// Throughput: one byte per cycle while the output is ready; a byte that causes several units
// (a surrogate pair, or a lead given up and the bytes behind it read again) holds the back
// part for one decode step per unit. A stalled output holds the back while the queue fills.
// Reset: queue and window empty, pair_enable = 1, replacement_unit = 0x003F; no clearing pass.
module utf8_to_utf16_transcoder
  import u8u16_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // configuration write port
  input  logic            cfg_we_i,
  input  cfg_idx_t        cfg_idx_i,
  input  logic [15:0]     cfg_wdata_i,
  // byte input
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      data_byte_i,
  input  logic            end_of_stream_i,
  // code unit output
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [15:0]     code_unit_o,
  output logic            last_of_run_o
);

  cfg_t   cfg_q;
  logic   head_valid, head_ready;
  qitem_t head;

  // Registers. Writes must come only while the block is idle (not enforced); applied at once.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pair_enable      <= PAIR_ENABLE_RST;
      cfg_q.replacement_unit <= REPL_UNIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PAIR_ENABLE: cfg_q.pair_enable      <= cfg_wdata_i[0];
        CFG_REPLACEMENT: cfg_q.replacement_unit <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Front: tag each byte with its form length and continuation flag, then queue it.
  // The queue lets the front keep taking bytes while the back replays or waits on output.
  u8u16_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .head_valid_o    (head_valid),
    .head_ready_i    (head_ready),
    .head_o          (head)
  );

  // Back: hold up to six pending bytes, run one decode step per cycle unless the output stalls,
  // and mark the last unit of each transaction by looking one step ahead. Its output register
  // parts the decode engine from the downstream handshake.
  u8u16_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .head_valid_i  (head_valid),
    .head_ready_o  (head_ready),
    .head_i        (head),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .code_unit_o   (code_unit_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

[hdl/u8u16_front.sv]
// Front part: classify incoming bytes and queue them for the decode engine.
module u8u16_front
  import u8u16_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_stream_i,
  output logic       head_valid_o,
  input  logic       head_ready_i,
  output qitem_t     head_o
);

  localparam int unsigned PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);

  qitem_t             slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FILL_W-1:0]  fill_q, fill_d;
  qitem_t             new_item;
  logic               push, pop;

  always_comb begin
    new_item.tb.data = data_byte_i;
    new_item.tb.flen = form_length(data_byte_i);
    new_item.tb.cont = is_cont(data_byte_i);
    new_item.eos     = end_of_stream_i;
  end

  assign in_ready_o   = fill_q != FILL_W'(QUEUE_DEPTH);
  assign head_valid_o = fill_q != '0;
  assign head_o       = slot_q[rd_ptr_q];

  assign push = in_valid_i && in_ready_o;
  assign pop  = head_valid_o && head_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    fill_d = fill_q + FILL_W'(push) - FILL_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

[hdl/u8u16_back.sv]
// Back part: pending byte window, one decode step per unstalled cycle, output register.
module u8u16_back
  import u8u16_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        head_valid_i,
  output logic        head_ready_o,
  input  qitem_t      head_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] code_unit_o,
  output logic        last_of_run_o
);

  tbyte_t      pend_q [BUF_DEPTH];
  tbyte_t      pend_d [BUF_DEPTH];
  tbyte_t      vbuf   [BUF_DEPTH];
  cnt_t        cnt_q, cnt_d, vcnt, avail, drop, navail;
  logic        in_step_q, in_step_d, eos_q, veos, lo_q, lo_d;
  logic [15:0] lo_unit_q;
  logic        out_valid_q, out_valid_d, out_last_q;
  logic [15:0] out_unit_q;

  logic        can_adv, fire, append_slot;
  logic        emit, set_lo, bad, short_seq, more;
  logic [15:0] unit;
  tbyte_t      lead, nlead;
  flen_t       len, nlen;
  logic [10:0] ucs2;
  logic [15:0] ucs3;
  logic [20:0] ucs4, v4;
  logic [15:0] hi_unit, lo_unit;
  logic [3:0]  sh;
  logic        nbad, nshort, nbrk;

  assign can_adv      = !out_valid_q || out_ready_i;
  assign fire         = can_adv && (in_step_q || head_valid_i);
  assign head_ready_o = can_adv && !in_step_q;
  assign append_slot  = !in_step_q && (cnt_q < cnt_t'(BUF_DEPTH));

  // Window seen by this cycle: the pending bytes, plus the queue head at the start of a step.
  always_comb begin
    for (int i = 0; i < BUF_DEPTH; i++) begin
      vbuf[i] = (append_slot && cnt_q == cnt_t'(i)) ? head_i.tb : pend_q[i];
    end
    vcnt = append_slot ? cnt_q + 1'b1 : cnt_q;
    veos = in_step_q ? eos_q : head_i.eos;
  end

  // Decode the sequence at the front of the window.
  always_comb begin
    lead      = vbuf[0];
    len       = lead.flen;
    short_seq = vcnt < cnt_t'(len);
    avail     = short_seq ? vcnt : cnt_t'(len);
    bad       = 1'b0;
    for (int i = 1; i < BUF_DEPTH; i++) begin
      if (cnt_t'(i) < avail && !vbuf[i].cont) begin
        bad = 1'b1;
      end
    end

    ucs2    = {lead.data[4:0], vbuf[1].data[5:0]};
    ucs3    = {lead.data[3:0], vbuf[1].data[5:0], vbuf[2].data[5:0]};
    ucs4    = {lead.data[2:0], vbuf[1].data[5:0], vbuf[2].data[5:0], vbuf[3].data[5:0]};
    v4      = ucs4 - SUPP_BASE;
    hi_unit = HI_SURR_FIRST | {6'b0, v4[19:10]};
    lo_unit = LO_SURR_FIRST | {6'b0, v4[9:0]};

    emit   = 1'b0;
    set_lo = 1'b0;
    unit   = '0;
    drop   = '0;

    priority if (vcnt == '0) begin
      // nothing pending
    end else if (lo_q) begin
      emit = 1'b1;
      unit = lo_unit_q;
      drop = cnt_t'(4);
    end else if (len < 3'd2) begin
      emit = 1'b1;
      unit = {8'h00, lead.data};
      drop = cnt_t'(1);
    end else if (bad || (short_seq && veos)) begin
      emit = 1'b1;
      unit = (len >= 3'd5) ? cfg_i.replacement_unit : {8'h00, lead.data};
      drop = cnt_t'(1);
    end else if (short_seq) begin
      // wait for more bytes
    end else begin
      emit = 1'b1;
      drop = cnt_t'(len);
      unique case (len)
        3'd2: unit = (ucs2 < MIN_TWO_BYTE) ? cfg_i.replacement_unit : {5'b0, ucs2};
        3'd3: begin
          if (ucs3 < MIN_THREE_BYTE || (ucs3 >= HI_SURR_FIRST && ucs3 <= HI_SURR_LAST)) begin
            unit = cfg_i.replacement_unit;
          end else begin
            unit = ucs3;
          end
        end
        3'd4: begin
          if (ucs4 < SUPP_BASE || ucs4 > CODE_MAX || !cfg_i.pair_enable) begin
            unit = cfg_i.replacement_unit;
          end else begin
            // high half now, low half on the next step; hold the bytes until then
            unit   = hi_unit;
            set_lo = 1'b1;
            drop   = '0;
          end
        end
        default: unit = cfg_i.replacement_unit;
      endcase
    end
  end

  // Advance the window and look ahead for whether this step has more units.
  always_comb begin
    for (int i = 0; i < BUF_DEPTH; i++) begin
      sh = 4'(i) + {1'b0, drop};
      pend_d[i] = (sh < 4'(BUF_DEPTH)) ? vbuf[sh[2:0]] : vbuf[i];
    end
    cnt_d  = vcnt - drop;

    nlead  = pend_d[0];
    nlen   = nlead.flen;
    nshort = cnt_d < cnt_t'(nlen);
    navail = nshort ? cnt_d : cnt_t'(nlen);
    nbad   = 1'b0;
    for (int i = 1; i < BUF_DEPTH; i++) begin
      if (cnt_t'(i) < navail && !pend_d[i].cont) begin
        nbad = 1'b1;
      end
    end
    nbrk = (nlen >= 3'd2) && !nbad && nshort && !veos;
    more = set_lo || (cnt_d != '0 && !nbrk);

    in_step_d   = emit && more;
    lo_d        = set_lo;
    out_valid_d = fire && emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      in_step_q   <= 1'b0;
      eos_q       <= 1'b0;
      lo_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        cnt_q     <= cnt_d;
        in_step_q <= in_step_d;
        eos_q     <= veos;
        lo_q      <= lo_d;
      end
      if (can_adv) begin
        out_valid_q <= out_valid_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      for (int i = 0; i < BUF_DEPTH; i++) begin
        pend_q[i] <= pend_d[i];
      end
      if (set_lo) begin
        lo_unit_q <= lo_unit;
      end
    end
    if (can_adv && out_valid_d) begin
      out_unit_q <= unit;
      out_last_q <= !more;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign code_unit_o   = out_unit_q;
  assign last_of_run_o = out_last_q;

  a_lo_in_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lo_q |-> in_step_q)
    else $error("low surrogate pending outside a step");

  a_step_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_step_q |-> cnt_q != '0)
    else $error("step continues with an empty window");

  a_idle_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_step_q |-> cnt_q < cnt_t'(BUF_DEPTH))
    else $error("no room for the next byte between steps");

  a_hi_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lo_q && out_valid_q) |-> !out_last_q)
    else $error("high surrogate marked as last of run");

endmodule

[verif/tb_utf8_to_utf16_transcoder.sv]
// Testbench for the UTF-8 to UTF-16 transcoder: directed and random byte streams with a predictor.
module tb_utf8_to_utf16_transcoder;
  import u8u16_pkg::*;

  // Hold this many cycles after the last expected unit before touching a register
  // or ending the run.
  localparam int unsigned SETTLE_CYCLES = 8;
  // Cycles without any transaction on either channel before the run is aborted.
  localparam int unsigned STALL_LIMIT   = 2000;
  // Random bytes per configuration phase.
  localparam int unsigned PHASE_BYTES   = 50;

  typedef struct packed {
    logic [15:0] code;
    logic        last;
  } utf16_unit_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  cfg_idx_t    cfg_idx_i;
  logic [15:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        end_of_stream_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] code_unit_o;
  logic        last_of_run_o;

  // Predictor state: bytes waiting for a decision and the register copies.
  logic [7:0]  held_bytes[$];
  logic        pair_on;
  logic [15:0] repl_unit;

  // Units still owed by the block, oldest first.
  utf16_unit_t units_due[$];
  utf16_unit_t head;

  int unsigned error_count;
  int unsigned idle_cycles;
  int unsigned burst_left;
  int unsigned phase_bytes;

  utf8_to_utf16_transcoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .end_of_stream_i(end_of_stream_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .code_unit_o    (code_unit_o),
    .last_of_run_o  (last_of_run_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Length of the form that a lead byte opens; 0 for bytes that never lead.
  function automatic int unsigned lead_span(input logic [7:0] b);
    if (b <= 8'h7F) return 1;
    if (b >= 8'hC0 && b <= 8'hDF) return 2;
    if (b >= 8'hE0 && b <= 8'hEF) return 3;
    if (b >= 8'hF0 && b <= 8'hF7) return 4;
    if (b >= 8'hF8 && b <= 8'hFB) return 5;
    if (b >= 8'hFC && b <= 8'hFD) return 6;
    return 0;
  endfunction

  // Append one accepted byte, decode from the front while a decision is possible,
  // and queue the resulting units with the run-end flag on the last one.
  function automatic void predict_byte(input logic [7:0] b, input logic eos);
    utf16_unit_t made[$];
    logic [7:0]  lead;
    int unsigned span;
    int unsigned reach;
    logic        broken;
    logic [20:0] cp;
    logic [19:0] off;
    held_bytes.push_back(b);
    while (held_bytes.size() > 0) begin
      lead = held_bytes[0];
      span = lead_span(lead);
      // ASCII goes out as is, stray bytes go out raw
      if (span <= 1) begin
        made.push_back({8'h00, lead, 1'b0});
        void'(held_bytes.pop_front());
        continue;
      end
      reach  = (held_bytes.size() < span) ? held_bytes.size() : span;
      broken = 1'b0;
      for (int unsigned i = 1; i < reach; i++) begin
        if (held_bytes[i][7:6] != 2'b10) broken = 1'b1;
      end
      // bad continuation or cut short: give up the lead only, reread the rest
      if (broken || (held_bytes.size() < span && eos)) begin
        made.push_back({(span >= 5) ? repl_unit : {8'h00, lead}, 1'b0});
        void'(held_bytes.pop_front());
        continue;
      end
      if (held_bytes.size() < span) break;
      case (span)
        2: begin
          cp = {10'd0, lead[4:0], held_bytes[1][5:0]};
          made.push_back({(cp < 21'h80) ? repl_unit : cp[15:0], 1'b0});
        end
        3: begin
          cp = {5'd0, lead[3:0], held_bytes[1][5:0], held_bytes[2][5:0]};
          if (cp < 21'h800 || (cp >= 21'hD800 && cp <= 21'hDBFF)) begin
            made.push_back({repl_unit, 1'b0});
          end else begin
            made.push_back({cp[15:0], 1'b0});
          end
        end
        4: begin
          cp = {lead[2:0], held_bytes[1][5:0], held_bytes[2][5:0], held_bytes[3][5:0]};
          if (cp < 21'h010000 || cp > 21'h10FFFF || !pair_on) begin
            made.push_back({repl_unit, 1'b0});
          end else begin
            off = cp[19:0] - 20'h10000;
            made.push_back({6'b110110, off[19:10], 1'b0});
            made.push_back({6'b110111, off[9:0], 1'b0});
          end
        end
        // complete five- and six-byte forms collapse into one replacement
        default: made.push_back({repl_unit, 1'b0});
      endcase
      repeat (span) void'(held_bytes.pop_front());
    end
    foreach (made[i]) begin
      made[i].last = (i == made.size() - 1);
      units_due.push_back(made[i]);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    error_count++;
    $display("MISMATCH %0s: got %04h, expected %04h", what, got, want);
  endtask

  // Compare every unit transaction with the oldest one owed.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (units_due.size() == 0) begin
        report_mismatch("code_unit with nothing due", code_unit_o, 16'h0000);
      end else begin
        head = units_due.pop_front();
        if (code_unit_o !== head.code)
          report_mismatch("code_unit", code_unit_o, head.code);
        if (last_of_run_o !== head.last)
          report_mismatch("last_of_run", {15'd0, last_of_run_o}, {15'd0, head.last});
      end
    end
  end

  // Count cycles in which neither channel moves a transaction.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // Abort a hung run.
  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready changes at the falling edge, on a pattern of its own that
  // switches between always ready, coin flips and long stalls.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned stall_left;
    out_ready_i = 1'b0;
    mode        = 0;
    mode_left   = 0;
    stall_left  = 0;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(30, 150);
      end
      mode_left--;
      case (mode)
        0: out_ready_i = 1'b1;
        1: out_ready_i = $urandom_range(0, 1);
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            out_ready_i = 1'b0;
          end else if ($urandom_range(0, 4) == 0) begin
            stall_left  = $urandom_range(1, 12);
            out_ready_i = 1'b0;
          end else begin
            out_ready_i = 1'b1;
          end
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sender. Every task below is entered and left at a falling edge. After a byte
  // transaction, valid stays high until the next send or settle drives it, so it
  // is never dropped and raised within one step.
  // ---------------------------------------------------------------------------

  // Present one byte, hold it until accepted, then feed the predictor.
  // Bursts of random length are separated by random gaps.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    if (burst_left == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      burst_left = $urandom_range(1, 60);
    end
    in_valid_i      = 1'b1;
    data_byte_i     = b;
    end_of_stream_i = eos;
    do @(posedge clk_i); while (!in_ready_o);
    predict_byte(b, eos);
    burst_left--;
    phase_bytes++;
    @(negedge clk_i);
  endtask

  // Send the first keep bytes of a form of the given length whose payload bits
  // come from payload; bits beyond the form's capacity are dropped.
  task automatic send_form(input int unsigned span, input logic [31:0] payload,
                           input int unsigned keep, input logic eos_last);
    logic [7:0] b;
    for (int unsigned i = 0; i < keep; i++) begin
      if (i == 0)
        b = (8'hFF << (8 - span)) |
            8'((payload >> (6 * (span - 1))) & ((32'd1 << (7 - span)) - 1));
      else
        b = 8'h80 | 8'((payload >> (6 * (span - 1 - i))) & 32'h3F);
      send_byte(b, eos_last && (i == keep - 1));
    end
  endtask

  // Drop valid and wait until the block owes nothing and has gone quiet.
  task automatic settle();
    in_valid_i = 1'b0;
    while (units_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Write both registers, one after the other; only called while the block is idle.
  task automatic set_config(input logic pair, input logic [15:0] repl);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = CFG_PAIR_ENABLE;
    cfg_wdata_i = {15'd0, pair};
    @(negedge clk_i);
    cfg_idx_i   = CFG_REPLACEMENT;
    cfg_wdata_i = repl;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    pair_on     = pair;
    repl_unit   = repl;
  endtask

  // One random sequence: mostly well-formed characters with random content,
  // the rest overlong or out-of-range forms, broken sequences and noise.
  task automatic send_random_sequence();
    int unsigned kind;
    int unsigned span;
    int unsigned keep;
    logic        tail_eos;
    logic [31:0] payload;
    logic [7:0]  b;
    kind     = $urandom_range(0, 99);
    tail_eos = ($urandom_range(0, 19) == 0);
    span     = $urandom_range(2, 6);
    // skew toward small values so overlong forms show up often
    payload  = $urandom >> $urandom_range(0, 31);
    if (kind < 20) begin
      send_byte(8'($urandom_range(0, 8'h7F)), tail_eos);
    end else if (kind < 35) begin
      send_form(2, $urandom_range(32'h80, 32'h7FF), 2, tail_eos);
    end else if (kind < 48) begin
      send_form(3, $urandom_range(32'h800, 32'hFFFF), 3, tail_eos);
    end else if (kind < 60) begin
      send_form(4, $urandom_range(32'h10000, 32'h10FFFF), 4, tail_eos);
    end else if (kind < 68) begin
      // both surrogate halves, only the high one is replaced
      send_form(3, $urandom_range(32'hD800, 32'hDFFF), 3, tail_eos);
    end else if (kind < 78) begin
      send_form(span, payload, span, tail_eos);
    end else if (kind < 90) begin
      keep = $urandom_range(1, span - 1);
      if ($urandom_range(0, 1)) begin
        // cut short by the end mark
        send_form(span, payload, keep, 1'b1);
      end else begin
        // break the form with a byte that is no continuation
        send_form(span, payload, keep, 1'b0);
        b = 8'($urandom_range(0, 255));
        if (b[7:6] == 2'b10) b[6] = 1'b1;
        send_byte(b, tail_eos);
      end
    end else begin
      send_byte(8'($urandom_range(0, 255)), tail_eos);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset defaults: field extremes, each form up to five bytes, and the decoding special cases.
  task automatic test_reset_defaults();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);               // never a lead, goes out raw
    send_form(2, 32'h0A9, 2, 1'b0);       // plain two-byte form
    send_form(2, 32'h07F, 2, 1'b0);       // overlong two-byte form
    send_form(3, 32'hD800, 3, 1'b0);      // high surrogate, replaced
    send_form(3, 32'hDC00, 3, 1'b0);      // low surrogate, passes
    send_form(4, 32'h10FFFF, 4, 1'b0);    // top of range, surrogate pair
    send_form(4, 32'h110000, 4, 1'b0);    // beyond range
    send_form(5, 32'h200000, 5, 1'b0);    // complete five-byte form
    send_byte(8'hC3, 1'b0);               // bad continuation: lead raw,
    send_byte(8'h41, 1'b0);               // then reread as ASCII
    send_form(3, 32'h20AC, 2, 1'b1);      // cut short by the end mark
    settle();
  endtask

  // A valid four-byte form with pairs turned off.
  task automatic test_pairs_disabled();
    set_config(1'b0, 16'hFFFD);
    send_form(4, 32'h1F600, 4, 1'b1);
    settle();
  endtask

  // Random traffic under one register setting; close with an end mark so the
  // buffer is empty before the next write.
  task automatic test_random_traffic(input logic pair, input logic [15:0] repl);
    set_config(pair, repl);
    phase_bytes = 0;
    while (phase_bytes < PHASE_BYTES) send_random_sequence();
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_PAIR_ENABLE;
    cfg_wdata_i     = 16'h0000;
    in_valid_i      = 1'b0;
    data_byte_i     = 8'h00;
    end_of_stream_i = 1'b0;
    pair_on         = PAIR_ENABLE_RST;
    repl_unit       = REPL_UNIT_RST;
    error_count     = 0;
    idle_cycles     = 0;
    burst_left      = 0;
    phase_bytes     = 0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_pairs_disabled();
    test_random_traffic(1'b0, 16'h0000);
    test_random_traffic(1'b1, 16'hFFFF);
    test_random_traffic(1'b0, 16'hFFFF);
    test_random_traffic(1'b1, 16'h0000);
    test_random_traffic(1'b1, 16'($urandom));
    test_random_traffic(1'b0, 16'($urandom));
    test_random_traffic(1'b1, REPL_UNIT_RST);

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
